// ===== design/atws_pkg.sv =====
package atws_pkg;

   // table geometry
   localparam int NUM_ALARMS = 5;
   localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

   // command codes
   localparam logic [2:0] CMD_CHECK   = 3'd0;
   localparam logic [2:0] CMD_SET     = 3'd1;
   localparam logic [2:0] CMD_ENABLE  = 3'd2;
   localparam logic [2:0] CMD_SNOOZE  = 3'd3;
   localparam logic [2:0] CMD_DISMISS = 3'd4;
   localparam logic [2:0] CMD_READ    = 3'd5;

   // time constants
   localparam logic [5:0] MAX_SNOOZE  = 6'd59;
   localparam logic [6:0] MINS_PER_HR = 7'd60;
   localparam logic [5:0] HRS_PER_DAY = 6'd24;

   typedef struct packed {
      logic [2:0] cmd;
      logic [3:0] alarm_id;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [5:0] now_second;
      logic       new_enabled;
      logic [4:0] new_hour;
      logic [5:0] new_minute;
      logic       new_repeat;
      logic [5:0] new_snooze;
   } req_type;

   typedef struct packed {
      logic [4:0] fired_mask;
      logic       id_valid;
      logic       rd_enabled;
      logic [4:0] rd_hour;
      logic [5:0] rd_minute;
      logic       rd_repeat;
      logic [5:0] rd_snooze;
   } rsp_type;

   // one table entry, 19 bits
   typedef struct packed {
      logic       enabled;
      logic [4:0] hour;
      logic [5:0] minute;
      logic       rep_daily;
      logic [5:0] snooze;
   } entry_type;

   // table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        entry;
   } mem_wr_type;

   // contents of an entry that was never written since reset
   function automatic entry_type reset_entry(input logic [IDX_W-1:0] idx);
      entry_type e;
      e.enabled   = (idx == '0);
      e.hour      = 5'd7;
      e.minute    = (idx == '0) ? 6'd30 : 6'd0;
      e.rep_daily = 1'b1;
      e.snooze    = 6'd5;
      return e;
   endfunction

endpackage

// ===== design/atws_if.sv =====
// request channel
interface atws_req_if;
   logic             valid;
   logic             ready;
   atws_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// response channel
interface atws_rsp_if;
   logic             valid;
   logic             ready;
   atws_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/atws_mem.sv =====
module atws_mem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [atws_pkg::IDX_W-1:0]        rd_addr,
   output atws_pkg::entry_type               rd_entry,
   input  atws_pkg::mem_wr_type              wr
);

   atws_pkg::entry_type               alarm_mem [atws_pkg::NUM_ALARMS];
   logic [atws_pkg::NUM_ALARMS-1:0]   valid_ff;
   atws_pkg::entry_type               rd_data_ff;
   logic                              rd_hit_ff;
   logic [atws_pkg::IDX_W-1:0]        rd_addr_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         alarm_mem[wr.addr] <= wr.entry;
      end
   end

   // written-since-reset flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= alarm_mem[rd_addr];
      rd_hit_ff  <= valid_ff[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // unwritten entries read as their reset contents
   assign rd_entry = rd_hit_ff ? rd_data_ff : atws_pkg::reset_entry(rd_addr_ff);

endmodule

// ===== design/atws_alu.sv =====
module atws_alu (
   input  atws_pkg::req_type    req,
   input  atws_pkg::entry_type  cur,
   output atws_pkg::mem_wr_type wr
);

   logic       id_ok;
   logic [6:0] min_sum;
   logic       min_wrap;
   logic [5:0] hour_inc;
   logic [5:0] snz_min;
   logic [4:0] snz_hour;
   logic [5:0] set_snooze;

   assign id_ok = req.alarm_id < 4'(atws_pkg::NUM_ALARMS);

   // snooze target: one hour wrap, then day wrap
   assign min_sum  = {1'b0, req.now_minute} + {1'b0, cur.snooze};
   assign min_wrap = min_sum >= atws_pkg::MINS_PER_HR;
   assign hour_inc = {1'b0, req.now_hour} + 6'd1;
   assign snz_min  = min_wrap ? 6'(min_sum - atws_pkg::MINS_PER_HR) : min_sum[5:0];
   assign snz_hour = !min_wrap ? req.now_hour :
                     (hour_inc >= atws_pkg::HRS_PER_DAY) ? 5'd0 : hour_inc[4:0];

   // set clamps the snooze length
   assign set_snooze = (req.new_snooze > atws_pkg::MAX_SNOOZE) ?
                       atws_pkg::MAX_SNOOZE : req.new_snooze;

   // per-command entry update
   always_comb begin
      wr.en    = 1'b0;
      wr.addr  = req.alarm_id[atws_pkg::IDX_W-1:0];
      wr.entry = cur;
      unique case (req.cmd)
         atws_pkg::CMD_SET: begin
            wr.en              = id_ok;
            wr.entry.enabled   = req.new_enabled;
            wr.entry.hour      = req.new_hour;
            wr.entry.minute    = req.new_minute;
            wr.entry.rep_daily = req.new_repeat;
            wr.entry.snooze    = set_snooze;
         end
         atws_pkg::CMD_ENABLE: begin
            wr.en            = id_ok;
            wr.entry.enabled = req.new_enabled;
         end
         atws_pkg::CMD_SNOOZE: begin
            wr.en           = id_ok;
            wr.entry.hour   = snz_hour;
            wr.entry.minute = snz_min;
         end
         atws_pkg::CMD_DISMISS: begin
            wr.en            = id_ok && !cur.rep_daily;
            wr.entry.enabled = 1'b0;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/alarm_table_with_snooze.sv =====
// Sequence: a check with second zero scans the entries, one per scan step, then
// finishes; a check with a nonzero second goes straight to finish; the rest modify first.
// Throughput: one transaction at a time, no new request until its response is queued;
// a new request is taken while the previous response still waits.
// Reset: synchronous, clears control, scan count and the table's written flags,
// so entry 0 reads as on at 07:30 and the others off at 07:00.
module alarm_table_with_snooze (
   input  logic       clock,
   input  logic       reset,
   atws_req_if.sink   req_ch,
   atws_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   atws_pkg::req_type            req_ff, req_in;
   logic [atws_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [4:0]                   mask_ff, mask_in;
   logic [2:0]                   scan_count_ff, scan_count_in;
   atws_pkg::entry_type          rdent_ff, rdent_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   atws_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [atws_pkg::IDX_W-1:0]   rd_addr;
   atws_pkg::entry_type          rd_entry;
   atws_pkg::mem_wr_type         alu_wr;
   atws_pkg::mem_wr_type         mem_wr;
   logic                         accept;
   logic                         in_id_ok;
   logic                         cur_id_ok;
   logic                         hit;
   logic                         rsp_free;

   atws_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr       (mem_wr)
   );

   atws_alu u_alu (
      .req (req_ff),
      .cur (rd_entry),
      .wr  (alu_wr)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_id_ok     = req_ch.data.alarm_id < 4'(atws_pkg::NUM_ALARMS);
   assign cur_id_ok    = req_ff.alarm_id < 4'(atws_pkg::NUM_ALARMS);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // table writes only in the modify step
   always_comb begin
      mem_wr    = alu_wr;
      mem_wr.en = alu_wr.en && (state_ff == ST_MODIFY);
   end

   // scan compare on the entry returned this cycle
   assign hit = (scan_count_ff > 3'(idx_ff)) && rd_entry.enabled &&
                (rd_entry.hour == req_ff.now_hour) &&
                (rd_entry.minute == req_ff.now_minute);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      mask_in       = mask_ff;
      scan_count_in = scan_count_ff;
      rdent_in      = rdent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // check scans from entry 0, other commands read the addressed entry (entry 0 when out of range)
            if (req_ch.data.cmd == atws_pkg::CMD_CHECK || !in_id_ok) begin
               rd_addr = '0;
            end else begin
               rd_addr = req_ch.data.alarm_id[atws_pkg::IDX_W-1:0];
            end
            if (accept) begin
               req_in  = req_ch.data;
               idx_in  = '0;
               mask_in = '0;
               if (req_ch.data.cmd == atws_pkg::CMD_CHECK) begin
                  state_in = (req_ch.data.now_second == '0) ? ST_SCAN : ST_FINISH;
               end else begin
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_SCAN: begin
            mask_in[idx_ff] = hit;
            rd_addr         = idx_ff + 1'b1;
            if (idx_ff == atws_pkg::IDX_W'(atws_pkg::NUM_ALARMS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_MODIFY: begin
            rdent_in = rd_entry;
            if (req_ff.cmd == atws_pkg::CMD_SET && cur_id_ok && req_ff.new_enabled &&
                req_ff.alarm_id >= {1'b0, scan_count_ff}) begin
               scan_count_in = 3'(req_ff.alarm_id) + 3'd1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = '0;
               rsp_data_in.fired_mask = mask_ff;
               rsp_data_in.id_valid = cur_id_ok;
               if (req_ff.cmd == atws_pkg::CMD_READ) begin
                  rsp_data_in.rd_enabled = rdent_ff.enabled;
                  rsp_data_in.rd_hour    = rdent_ff.hour;
                  rsp_data_in.rd_minute  = rdent_ff.minute;
                  rsp_data_in.rd_repeat  = rdent_ff.rep_daily;
                  rsp_data_in.rd_snooze  = rdent_ff.snooze;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_count_ff <= scan_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      mask_ff     <= mask_in;
      rdent_ff    <= rdent_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

// ===== tb/sv/alarm_table_with_snooze_tb.sv =====
module alarm_table_with_snooze_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import atws_pkg::*;

   // spare command codes the block must ignore
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS = 1130;
   localparam int DRAIN_EVERY  = 250;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      req_type req;
      bit      drain_first;   // wait for all answers before sending this one
   } queued_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   atws_req_if req_bus ();
   atws_rsp_if rsp_bus ();

   alarm_table_with_snooze uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // shadow copy of the alarm table
   entry_type   alarm_tab [NUM_ALARMS];
   logic [2:0]  scan_limit;

   queued_cmd_type req_backlog [$];
   rsp_type     due_answers [$];

   int unsigned n_accepted = 0;
   int unsigned n_answered = 0;
   int          n_errors   = 0;
   int          cmd_seen [8];
   int          fire_count = 0;

   int          gap_left   = 0;
   int          burst_left = 0;
   logic [15:0] ready_pattern = 16'hFFFF;
   logic [5:0]  stall_phase   = '0;

   always #2 clock = ~clock;

   // known values on every block input from time zero
   initial begin
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic void clear_alarm_tab();
      for (int i = 0; i < NUM_ALARMS; i++) begin
         alarm_tab[i].enabled   = (i == 0);
         alarm_tab[i].hour      = 5'd7;
         alarm_tab[i].minute    = (i == 0) ? 6'd30 : 6'd0;
         alarm_tab[i].rep_daily = 1'b1;
         alarm_tab[i].snooze    = 6'd5;
      end
      scan_limit = '0;
   endfunction

   // apply one command to the shadow table and return its answer
   function automatic rsp_type run_alarm_cmd(input req_type r);
      rsp_type o;
      logic    id_ok;
      int      idx;
      int      m;
      int      h;
      o     = '0;
      id_ok = (r.alarm_id < NUM_ALARMS);
      idx   = id_ok ? int'(r.alarm_id) : 0;
      case (r.cmd)
         CMD_CHECK: begin
            if (r.now_second == 0) begin
               for (int i = 0; i < NUM_ALARMS; i++)
                  if (i < scan_limit && alarm_tab[i].enabled &&
                      alarm_tab[i].hour == r.now_hour &&
                      alarm_tab[i].minute == r.now_minute)
                     o.fired_mask[i] = 1'b1;
            end
         end
         CMD_SET: begin
            if (id_ok) begin
               alarm_tab[idx].enabled   = r.new_enabled;
               alarm_tab[idx].hour      = r.new_hour;
               alarm_tab[idx].minute    = r.new_minute;
               alarm_tab[idx].rep_daily = r.new_repeat;
               alarm_tab[idx].snooze    = (r.new_snooze > MAX_SNOOZE) ? MAX_SNOOZE
                                                                      : r.new_snooze;
               if (r.new_enabled && r.alarm_id >= scan_limit)
                  scan_limit = 3'(r.alarm_id + 1);
            end
         end
         CMD_ENABLE: begin
            if (id_ok) alarm_tab[idx].enabled = r.new_enabled;
         end
         CMD_SNOOZE: begin
            if (id_ok) begin
               m = int'(r.now_minute) + int'(alarm_tab[idx].snooze);
               h = int'(r.now_hour);
               // single hour wrap, then day wrap
               if (m >= int'(MINS_PER_HR)) begin
                  m = m - int'(MINS_PER_HR);
                  h = h + 1;
                  if (h >= int'(HRS_PER_DAY)) h = 0;
               end
               alarm_tab[idx].hour   = 5'(h);
               alarm_tab[idx].minute = 6'(m);
            end
         end
         CMD_DISMISS: begin
            if (id_ok && !alarm_tab[idx].rep_daily) alarm_tab[idx].enabled = 1'b0;
         end
         CMD_READ: begin
            o.rd_enabled = alarm_tab[idx].enabled;
            o.rd_hour    = alarm_tab[idx].hour;
            o.rd_minute  = alarm_tab[idx].minute;
            o.rd_repeat  = alarm_tab[idx].rep_daily;
            o.rd_snooze  = alarm_tab[idx].snooze;
         end
         default: ;
      endcase
      o.id_valid = id_ok;
      return o;
   endfunction

   function automatic req_type build_cmd(input logic [2:0] cmd, input int id,
                                         input int nh, input int nm, input int ns,
                                         input int en, input int hr, input int mn,
                                         input int rp, input int sz);
      req_type r;
      r.cmd         = cmd;
      r.alarm_id    = 4'(id);
      r.now_hour    = 5'(nh);
      r.now_minute  = 6'(nm);
      r.now_second  = 6'(ns);
      r.new_enabled = 1'(en);
      r.new_hour    = 5'(hr);
      r.new_minute  = 6'(mn);
      r.new_repeat  = 1'(rp);
      r.new_snooze  = 6'(sz);
      return r;
   endfunction

   // times come mostly from a small pool so checks actually hit alarms
   function automatic req_type random_cmd();
      req_type r;
      int      pick;
      bit      wide;
      pick = $urandom_range(0, 99);
      wide = ($urandom_range(0, 9) == 0);
      if (pick < 30)      r.cmd = CMD_CHECK;
      else if (pick < 50) r.cmd = CMD_SET;
      else if (pick < 60) r.cmd = CMD_ENABLE;
      else if (pick < 70) r.cmd = CMD_SNOOZE;
      else if (pick < 80) r.cmd = CMD_DISMISS;
      else if (pick < 97) r.cmd = CMD_READ;
      else                r.cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      r.alarm_id    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, NUM_ALARMS - 1));
      r.now_hour    = wide ? 5'($urandom_range(0, 31)) : 5'($urandom_range(6, 8));
      r.now_minute  = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3) * 15);
      r.now_second  = ($urandom_range(0, 9) < 6) ? 6'd0 : 6'($urandom_range(0, 63));
      r.new_enabled = ($urandom_range(0, 3) != 0);
      r.new_hour    = wide ? 5'($urandom_range(0, 31)) : 5'($urandom_range(6, 8));
      r.new_minute  = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3) * 15);
      r.new_repeat  = 1'($urandom_range(0, 1));
      r.new_snooze  = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3) * 15);
      return r;
   endfunction

   task automatic queue_cmd(input req_type r, input bit drain);
      queued_cmd_type q;
      q.req         = r;
      q.drain_first = drain;
      req_backlog.push_back(q);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         n_errors++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // request driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left != 0) begin
            req_bus.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (req_backlog.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (req_backlog[0].drain_first &&
                      (req_bus.valid || n_accepted != n_answered)) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.data  <= req_backlog[0].req;
            req_bus.valid <= 1'b1;
            void'(req_backlog.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // response backpressure: a 16-bit ready pattern, replaced when the phase counter wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_phase   <= '0;
      end else begin
         rsp_bus.ready <= ready_pattern[stall_phase[3:0]];
         stall_phase   <= stall_phase + 1;
         if (stall_phase == '1) begin
            case ($urandom_range(0, 3))
               0:       ready_pattern <= 16'hFFFF;
               1:       ready_pattern <= 16'($urandom);
               2:       ready_pattern <= 16'h0001;
               default: ready_pattern <= 16'($urandom | $urandom);
            endcase
         end
      end
   end

   // monitor: predict on request transactions, check on response transactions
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            due_answers.push_back(run_alarm_cmd(req_bus.data));
            cmd_seen[req_bus.data.cmd]++;
            n_accepted <= n_accepted + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            n_answered <= n_answered + 1;
            if (due_answers.size() == 0) begin
               n_errors++;
               $error("response with no request outstanding");
            end else begin
               want = due_answers.pop_front();
               if (want.fired_mask != 0) fire_count++;
               check_field("fired_mask", want.fired_mask, got.fired_mask);
               check_field("id_valid",   want.id_valid,   got.id_valid);
               check_field("rd_enabled", want.rd_enabled, got.rd_enabled);
               check_field("rd_hour",    want.rd_hour,    got.rd_hour);
               check_field("rd_minute",  want.rd_minute,  got.rd_minute);
               check_field("rd_repeat",  want.rd_repeat,  got.rd_repeat);
               check_field("rd_snooze",  want.rd_snooze,  got.rd_snooze);
            end
         end
      end
   end

   // stimulus and end of test
   initial begin
      clear_alarm_tab();

      // reset contents, then an out-of-range read that falls back to entry 0
      for (int i = 0; i < NUM_ALARMS; i++)
         queue_cmd(build_cmd(CMD_READ, i, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_cmd(build_cmd(CMD_READ, 15, 31, 63, 63, 1, 31, 63, 1, 63), 1'b0);
      // entry 0 is on at reset but scan count is still zero
      queue_cmd(build_cmd(CMD_CHECK, 0, 7, 30, 0, 0, 0, 0, 0, 0), 1'b0);
      // set raises the scan count; snooze length saturates
      queue_cmd(build_cmd(CMD_SET, 2, 0, 0, 0, 1, 7, 30, 0, 63), 1'b0);
      queue_cmd(build_cmd(CMD_CHECK, 0, 7, 30, 0, 0, 0, 0, 0, 0), 1'b1);
      queue_cmd(build_cmd(CMD_CHECK, 0, 7, 30, 1, 0, 0, 0, 0, 0), 1'b0);
      // snooze across midnight
      queue_cmd(build_cmd(CMD_SNOOZE, 2, 23, 50, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_cmd(build_cmd(CMD_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      // dismiss: one-shot entry goes off, daily entry stays on
      queue_cmd(build_cmd(CMD_DISMISS, 2, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_cmd(build_cmd(CMD_DISMISS, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_cmd(build_cmd(CMD_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_cmd(build_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_cmd(build_cmd(CMD_ENABLE, 2, 0, 0, 0, 1, 0, 0, 0, 0), 1'b0);
      queue_cmd(build_cmd(CMD_ENABLE, 7, 0, 0, 0, 1, 0, 0, 0, 0), 1'b0);
      // disabled set leaves scan count alone, enabled one opens the top entry
      queue_cmd(build_cmd(CMD_SET, 4, 0, 0, 0, 0, 8, 0, 0, 10), 1'b0);
      queue_cmd(build_cmd(CMD_SET, 4, 0, 0, 0, 1, 31, 63, 1, 0), 1'b0);
      queue_cmd(build_cmd(CMD_CHECK, 0, 31, 63, 0, 0, 0, 0, 0, 0), 1'b0);
      // ignored writes and spare commands
      queue_cmd(build_cmd(CMD_SET, 9, 0, 0, 0, 1, 1, 1, 0, 1), 1'b0);
      queue_cmd(build_cmd(CMD_SPARE_A, 1, 7, 30, 0, 1, 7, 30, 1, 5), 1'b0);
      queue_cmd(build_cmd(CMD_SPARE_B, 12, 7, 30, 0, 1, 7, 30, 1, 5), 1'b0);
      // raw out-of-range time through snooze
      queue_cmd(build_cmd(CMD_SNOOZE, 4, 31, 63, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_cmd(build_cmd(CMD_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++)
         queue_cmd(random_cmd(), (i % DRAIN_EVERY) == DRAIN_EVERY - 1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_bus.valid || n_accepted != n_answered)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (due_answers.size() != 0) begin
         n_errors++;
         $error("%0d responses never arrived", due_answers.size());
      end

      $display("%0d transactions: %0d checks (%0d fired), %0d sets, %0d enables,",
               n_accepted, cmd_seen[CMD_CHECK], fire_count, cmd_seen[CMD_SET],
               cmd_seen[CMD_ENABLE]);
      $display("  %0d snoozes, %0d dismisses, %0d reads, %0d spare commands",
               cmd_seen[CMD_SNOOZE], cmd_seen[CMD_DISMISS], cmd_seen[CMD_READ],
               cmd_seen[CMD_SPARE_A] + cmd_seen[CMD_SPARE_B]);

      if (n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
design/atws_pkg.sv
design/atws_if.sv
design/atws_mem.sv
design/atws_alu.sv
design/alarm_table_with_snooze.sv
tb/sv/alarm_table_with_snooze_tb.sv
